[src/ttsch_pkg.sv]
package ttsch_pkg;

    // Table size and the widths that follow from it.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Field widths.
    localparam int ID_W   = 31;
    localparam int TIME_W = 48;
    localparam int IVL_W  = 31;
    localparam int SPAN_W = 41;
    localparam int DL_W   = TIME_W + 1;
    localparam int DIFF_W = DL_W + 1;
    localparam int WAIT_W = 41;

    // Constants.
    localparam logic [ID_W-1:0]   ID_TOP    = {ID_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX  = 41'd2147483647000;
    localparam logic [SPAN_W-1:0] MS_TO_US  = 41'd1000;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_CANCEL   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_QUERY    = 2'd3
    } t_cmd;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ID    = 3'd0,
        KIND_FULL  = 3'd1,
        KIND_FIRED = 3'd2,
        KIND_WAIT  = 3'd3,
        KIND_NONE  = 3'd4
    } t_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_CLAMP
    } t_state;

    // One slot of the table; the span is the interval already in microseconds.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SPAN_W-1:0] span;
        logic              rep;
        logic [TIME_W-1:0] start;
    } t_slot_entry;

    // Write request towards the slot memory.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot_entry       entry;
    } t_slot_wr;

    // Next id after c: steps by one, skips zero and the reserved top value.
    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] c);
        logic [ID_W-1:0] s;
        s = c + ID_W'(1);
        if (s == ID_TOP || s == '0) begin
            s = ID_W'(1);
        end
        return s;
    endfunction

endpackage

[src/timer_table_scheduler.sv]
// Timer slot table driven by single commands. A transaction is taken when
// start is high and busy is low; busy then stays high while the table is walked,
// and the final result of a command appears in the same cycle as busy falls.
// Each command walks the whole table through one memory read port and one
// shared deadline adder and comparator, one slot a cycle; cancel, tick and
// query walk it once, and schedule walks it once more for every candidate id
// it has to skip because that id is already held by a slot. Results appear on
// o_strobe for exactly one cycle each and cannot be held off; a tick gives one
// result per fired timer, in slot order as the walk finds them, and o_last
// marks the final result of a command.
// Cancel, and a tick that fires nothing, give no result at all.
module timer_table_scheduler
    import ttsch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [TIME_W-1:0] i_now_us,
    input  logic [IVL_W-1:0]  i_interval_ms,
    input  logic              i_repeat_flag,
    input  logic [ID_W-1:0]   i_cancel_id,
    output logic              o_strobe,
    output logic [2:0]        o_result_kind,
    output logic [ID_W-1:0]   o_task_id,
    output logic [WAIT_W-1:0] o_wait_us,
    output logic              o_last
);

    // Sequencer and control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SLOTS-1:0]   r_used, n_used;
    logic [ID_W-1:0]    r_last_id, n_last_id;
    logic               r_free_found, n_free_found;
    logic [SLOT_W-1:0]  r_free_idx, n_free_idx;
    logic               r_cand_hit, n_cand_hit;
    logic               r_found, n_found;
    logic               r_pend_valid, n_pend_valid;
    logic               r_strobe, n_strobe;

    // Latched command and working values.
    t_cmd               r_cmd, n_cmd;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [SPAN_W-1:0]  r_span, n_span;
    logic               r_rep, n_rep;
    logic [ID_W-1:0]    r_cid, n_cid;
    logic [ID_W-1:0]    r_cand, n_cand;
    logic [DL_W-1:0]    r_best, n_best;
    logic [DIFF_W-1:0]  r_diff, n_diff;
    logic [ID_W-1:0]    r_pend_id, n_pend_id;

    // Result registers.
    t_kind              r_kind, n_kind;
    logic [ID_W-1:0]    r_tid, n_tid;
    logic [WAIT_W-1:0]  r_wait, n_wait;
    logic               r_last, n_last;

    // Memory interface and shared unit.
    t_slot_wr           mem_wr;
    logic [SLOT_W-1:0]  mem_rd_addr;
    t_slot_entry        mem_rd;
    logic               accept;
    logic               scan_end;
    logic [SLOT_W-1:0]  ev_idx;
    logic               ev_used;
    logic [DL_W-1:0]    deadline;
    logic [DL_W-1:0]    cmp_b;
    logic               dl_less;
    logic [ID_W-1:0]    eq_b;
    logic               id_eq;

    ttsch_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd)
    );

    assign accept   = start && (r_state == ST_IDLE);
    assign scan_end = (r_cnt == CNT_W'(SLOTS));

    // The slot under evaluation is the one addressed in the previous cycle.
    assign mem_rd_addr = r_cnt[SLOT_W-1:0];
    assign ev_idx      = SLOT_W'(r_cnt - CNT_W'(1));
    assign ev_used     = r_used[ev_idx];

    // Shared deadline adder with one comparator for tick and query.
    assign deadline = DL_W'(mem_rd.start) + DL_W'(mem_rd.span);
    assign cmp_b    = (r_cmd == CMD_TICK) ? DL_W'(r_now) : r_best;
    assign dl_less  = deadline < cmp_b;

    // Shared id comparator for the candidate check and for cancel.
    assign eq_b  = (r_cmd == CMD_SCHEDULE) ? r_cand : r_cid;
    assign id_eq = (mem_rd.id == eq_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (r_cmd == CMD_SCHEDULE && r_free_found && r_cand_hit) begin
                    n_state = ST_SCAN;
                end else if (r_cmd == CMD_QUERY && r_found) begin
                    n_state = ST_CLAMP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLAMP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and result control.
    always_comb begin
        n_cnt        = r_cnt;
        n_used       = r_used;
        n_last_id    = r_last_id;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cand_hit   = r_cand_hit;
        n_found      = r_found;
        n_pend_valid = r_pend_valid;
        n_cmd        = r_cmd;
        n_now        = r_now;
        n_span       = r_span;
        n_rep        = r_rep;
        n_cid        = r_cid;
        n_cand       = r_cand;
        n_best       = r_best;
        n_diff       = r_diff;
        n_pend_id    = r_pend_id;
        n_strobe     = 1'b0;
        n_kind       = r_kind;
        n_tid        = r_tid;
        n_wait       = r_wait;
        n_last       = r_last;
        mem_wr       = '0;

        unique case (r_state)
            ST_IDLE: begin
                // Take the command and prime the scan.
                if (accept) begin
                    n_cmd        = t_cmd'(i_command);
                    n_now        = i_now_us;
                    n_span       = SPAN_W'(i_interval_ms) * MS_TO_US;
                    n_rep        = i_repeat_flag;
                    n_cid        = i_cancel_id;
                    n_cand       = next_id(r_last_id);
                    n_cnt        = '0;
                    n_free_found = 1'b0;
                    n_cand_hit   = 1'b0;
                    n_found      = 1'b0;
                    n_pend_valid = 1'b0;
                end
            end

            ST_SCAN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    unique case (r_cmd)
                        CMD_SCHEDULE: begin
                            if (!ev_used && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = ev_idx;
                            end
                            if (ev_used && id_eq) begin
                                n_cand_hit = 1'b1;
                            end
                        end
                        CMD_CANCEL: begin
                            if (ev_used && id_eq && r_cid != '0) begin
                                n_used[ev_idx] = 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            if (ev_used && dl_less) begin
                                // Restart or free the slot.
                                if (mem_rd.rep) begin
                                    mem_wr.en          = 1'b1;
                                    mem_wr.addr        = ev_idx;
                                    mem_wr.entry       = mem_rd;
                                    mem_wr.entry.start = r_now;
                                end else begin
                                    n_used[ev_idx] = 1'b0;
                                end
                                // The previous fire is now known not to be the last.
                                if (r_pend_valid) begin
                                    n_strobe = 1'b1;
                                    n_kind   = KIND_FIRED;
                                    n_tid    = r_pend_id;
                                    n_wait   = '0;
                                    n_last   = 1'b0;
                                end
                                n_pend_valid = 1'b1;
                                n_pend_id    = mem_rd.id;
                            end
                        end
                        CMD_QUERY: begin
                            if (ev_used && (!r_found || dl_less)) begin
                                n_found = 1'b1;
                                n_best  = deadline;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_DONE: begin
                unique case (r_cmd)
                    CMD_SCHEDULE: begin
                        if (!r_free_found) begin
                            n_strobe = 1'b1;
                            n_kind   = KIND_FULL;
                            n_tid    = '0;
                            n_wait   = '0;
                            n_last   = 1'b1;
                        end else if (r_cand_hit) begin
                            // Candidate is taken: try the next one.
                            n_cand     = next_id(r_cand);
                            n_cand_hit = 1'b0;
                            n_cnt      = '0;
                        end else begin
                            mem_wr.en          = 1'b1;
                            mem_wr.addr        = r_free_idx;
                            mem_wr.entry.id    = r_cand;
                            mem_wr.entry.span  = r_span;
                            mem_wr.entry.rep   = r_rep;
                            mem_wr.entry.start = r_now;
                            n_used[r_free_idx] = 1'b1;
                            n_last_id          = r_cand;
                            n_strobe           = 1'b1;
                            n_kind             = KIND_ID;
                            n_tid              = r_cand;
                            n_wait             = '0;
                            n_last             = 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        if (r_pend_valid) begin
                            n_strobe = 1'b1;
                            n_kind   = KIND_FIRED;
                            n_tid    = r_pend_id;
                            n_wait   = '0;
                            n_last   = 1'b1;
                        end
                        n_pend_valid = 1'b0;
                    end
                    CMD_QUERY: begin
                        if (!r_found) begin
                            n_strobe = 1'b1;
                            n_kind   = KIND_NONE;
                            n_tid    = '0;
                            n_wait   = '0;
                            n_last   = 1'b1;
                        end else begin
                            n_diff = {1'b0, r_best} - DIFF_W'(r_now);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_CLAMP: begin
                // Clamp at zero and saturate at WAIT_MAX, the largest interval in microseconds.
                n_strobe = 1'b1;
                n_kind   = KIND_WAIT;
                n_tid    = '0;
                n_last   = 1'b1;
                if (r_diff[DIFF_W-1]) begin
                    n_wait = '0;
                end else if (r_diff > DIFF_W'(WAIT_MAX)) begin
                    n_wait = WAIT_MAX;
                end else begin
                    n_wait = r_diff[WAIT_W-1:0];
                end
            end

            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_used       <= '0;
            r_last_id    <= '0;
            r_free_found <= 1'b0;
            r_cand_hit   <= 1'b0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_used       <= n_used;
            r_last_id    <= n_last_id;
            r_free_found <= n_free_found;
            r_cand_hit   <= n_cand_hit;
            r_found      <= n_found;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        r_cmd      <= n_cmd;
        r_now      <= n_now;
        r_span     <= n_span;
        r_rep      <= n_rep;
        r_cid      <= n_cid;
        r_cand     <= n_cand;
        r_best     <= n_best;
        r_diff     <= n_diff;
        r_pend_id  <= n_pend_id;
        r_kind     <= n_kind;
        r_tid      <= n_tid;
        r_wait     <= n_wait;
        r_last     <= n_last;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_task_id     = r_tid;
    assign o_wait_us     = r_wait;
    assign o_last        = r_last;

    // An accepted transaction always starts a table walk.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not start a scan");

    // A table-full report is a single result carrying no id.
    a_full_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result_kind == KIND_FULL |-> o_last && o_task_id == '0)
        else $error("table-full result malformed");

    // An assigned id is never zero nor the reserved top value.
    a_id_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result_kind == KIND_ID |-> o_task_id != '0 && o_task_id != ID_TOP)
        else $error("illegal id assigned");

    // The clamp cycle always produces the final wait result.
    a_clamp_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLAMP |=> o_strobe && o_last && o_result_kind == KIND_WAIT)
        else $error("query did not report a wait");

    // No fired timer is left pending once the block is idle.
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_pend_valid)
        else $error("fired timer lost at end of tick");

endmodule

[src/ttsch_slot_mem.sv]
module ttsch_slot_mem
    import ttsch_pkg::*;
(
    input  logic              i_clk,
    input  t_slot_wr          i_wr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_slot_entry       o_rd_data
);

    // Slot contents; occupancy is tracked outside, so no reset here.
    t_slot_entry r_mem [SLOTS];
    t_slot_entry r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ttsch_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * (SLOTS + 3);
    localparam int MAX_GAP        = 25;

    // One expected result of a command.
    typedef struct {
        t_kind             kind;
        logic [ID_W-1:0]   task_id;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_timer_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [TIME_W-1:0] i_now_us;
    logic [IVL_W-1:0]  i_interval_ms;
    logic              i_repeat_flag;
    logic [ID_W-1:0]   i_cancel_id;
    logic              o_strobe;
    logic [2:0]        o_result_kind;
    logic [ID_W-1:0]   o_task_id;
    logic [WAIT_W-1:0] o_wait_us;
    logic              o_last;

    // Shadow copy of the slot table, kept in step with accepted transactions.
    logic [ID_W-1:0]   tbl_id    [SLOTS];
    logic [IVL_W-1:0]  tbl_ivl   [SLOTS];
    logic              tbl_rep   [SLOTS];
    logic [TIME_W-1:0] tbl_start [SLOTS];
    logic [ID_W-1:0]   prev_issued_id;

    t_timer_result     pending_results[$];
    int                mismatch_count;
    int                idle_cycles;
    logic [TIME_W-1:0] wall_clock_us;

    timer_table_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_now_us      (i_now_us),
        .i_interval_ms (i_interval_ms),
        .i_repeat_flag (i_repeat_flag),
        .i_cancel_id   (i_cancel_id),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_task_id     (o_task_id),
        .o_wait_us     (o_wait_us),
        .o_last        (o_last)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Deadline of an occupied slot, wide enough that it never wraps.
    function automatic logic [63:0] deadline_us(int s);
        return 64'(tbl_start[s]) + 64'(tbl_ivl[s]) * 64'd1000;
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    task automatic push_result(t_kind kind, logic [ID_W-1:0] id, logic [WAIT_W-1:0] w,
                               logic last);
        pending_results.push_back('{kind, id, w, last});
    endtask

    // Works out the results of one accepted transaction and updates the shadow table.
    task automatic predict_timer_results(t_cmd cmd, logic [TIME_W-1:0] now_us,
                                         logic [IVL_W-1:0] ivl, logic rep,
                                         logic [ID_W-1:0] cid);
        int          free_slot;
        int          last_fire;
        logic        held;
        logic        found;
        logic [ID_W-1:0] cand;
        logic [63:0] best;
        logic [63:0] w;
        free_slot = -1;
        last_fire = -1;
        found     = 1'b0;
        best      = '0;
        case (cmd)
            CMD_SCHEDULE: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_id[s] == '0 && free_slot < 0) free_slot = s;
                end
                if (free_slot < 0) begin
                    push_result(KIND_FULL, '0, '0, 1'b1);
                end else begin
                    // Step the id counter past zero, the reserved top value and ids in use.
                    cand = prev_issued_id;
                    forever begin
                        cand = cand + 1'b1;
                        if (cand == ID_TOP || cand == '0) cand = ID_W'(1);
                        held = 1'b0;
                        for (int s = 0; s < SLOTS; s++) begin
                            if (tbl_id[s] == cand) held = 1'b1;
                        end
                        if (!held) break;
                    end
                    prev_issued_id       = cand;
                    tbl_id[free_slot]    = cand;
                    tbl_ivl[free_slot]   = ivl;
                    tbl_rep[free_slot]   = rep;
                    tbl_start[free_slot] = now_us;
                    push_result(KIND_ID, cand, '0, 1'b1);
                end
            end
            CMD_CANCEL: begin
                if (cid != '0) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (tbl_id[s] == cid) tbl_id[s] = '0;
                    end
                end
            end
            CMD_TICK: begin
                // Slots fire independently, so the final firing slot is known up front.
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_id[s] != '0 && deadline_us(s) < 64'(now_us)) last_fire = s;
                end
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_id[s] != '0 && deadline_us(s) < 64'(now_us)) begin
                        push_result(KIND_FIRED, tbl_id[s], '0, s == last_fire);
                        if (tbl_rep[s]) tbl_start[s] = now_us;
                        else tbl_id[s] = '0;
                    end
                end
            end
            default: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_id[s] != '0 && (!found || deadline_us(s) < best)) begin
                        best  = deadline_us(s);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    push_result(KIND_NONE, '0, '0, 1'b1);
                end else begin
                    w = (best > 64'(now_us)) ? best - 64'(now_us) : 64'd0;
                    if (w > 64'(WAIT_MAX)) w = 64'(WAIT_MAX);
                    push_result(KIND_WAIT, '0, w[WAIT_W-1:0], 1'b1);
                end
            end
        endcase
    endtask

    // Presents one command and waits until the block takes it. Start is left high.
    task automatic send_timer_cmd(t_cmd cmd, logic [TIME_W-1:0] now_us,
                                  logic [IVL_W-1:0] ivl, logic rep, logic [ID_W-1:0] cid);
        i_command     <= cmd;
        i_now_us      <= now_us;
        i_interval_ms <= ivl;
        i_repeat_flag <= rep;
        i_cancel_id   <= cid;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_timer_results(cmd, now_us, ivl, rep, cid);
    endtask

    // Random gap on the command side.
    task automatic hold_off(int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
    endtask

    task automatic flag_mismatch(string what, logic [63:0] expv, logic [63:0] gotv);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, what, expv, gotv);
        end
    endtask

    task automatic check_field(string what, logic [63:0] expv, logic [63:0] gotv);
        if (expv !== gotv) flag_mismatch(what, expv, gotv);
    endtask

    // Each strobed result is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_timer_result exp_res;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, kind", '0, 64'(o_result_kind));
            end else begin
                exp_res = pending_results.pop_front();
                check_field("result_kind", 64'(exp_res.kind), 64'(o_result_kind));
                check_field("task_id", 64'(exp_res.task_id), 64'(o_task_id));
                check_field("wait_us", 64'(exp_res.wait_us), 64'(o_wait_us));
                check_field("last", 64'(exp_res.last), 64'(o_last));
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Query on an empty table reports that nothing is pending.
    task automatic test_empty_query();
        send_timer_cmd(CMD_QUERY, random_time(), '0, 1'b0, '0);
    endtask

    // A deadline equal to now neither fires nor leaves a wait; one microsecond later it fires.
    task automatic test_deadline_edges();
        send_timer_cmd(CMD_SCHEDULE, 48'd1000, '0, 1'b0, '0);
        send_timer_cmd(CMD_SCHEDULE, 48'd1000, {IVL_W{1'b1}}, 1'b1, '0);
        send_timer_cmd(CMD_QUERY, 48'd1000, '0, 1'b0, '0);
        send_timer_cmd(CMD_TICK, 48'd1000, '0, 1'b0, '0);
        send_timer_cmd(CMD_TICK, 48'd1001, '0, 1'b0, '0);
    endtask

    // Cancelling id zero or an id that is not held changes nothing.
    task automatic test_cancel_noop();
        send_timer_cmd(CMD_CANCEL, 48'd1002, '0, 1'b0, '0);
        send_timer_cmd(CMD_CANCEL, 48'd1003, '0, 1'b0, 31'h5A5A_1234);
    endtask

    // Time running backwards gives a wait beyond the maximum, which saturates.
    task automatic test_wait_saturation();
        send_timer_cmd(CMD_QUERY, '0, '0, 1'b0, '0);
    endtask

    // Fill every slot, overflow once, then fire the whole table in one tick.
    task automatic test_table_full();
        for (int i = 0; i < SLOTS - 1; i++) begin
            send_timer_cmd(CMD_SCHEDULE, 48'd2000 + 48'(i), IVL_W'($urandom_range(0, 50)),
                           1'b0, '0);
        end
        send_timer_cmd(CMD_SCHEDULE, 48'd3000, 31'd7, 1'b1, '0);
        send_timer_cmd(CMD_TICK, {TIME_W{1'b1}}, '0, 1'b0, '0);
    endtask

    // Random command mix with a time base that mostly moves forward in small steps.
    task automatic test_random(int n_items, int idle_pct);
        int                pick;
        t_cmd              cmd;
        logic [TIME_W-1:0] now_us;
        logic [IVL_W-1:0]  ivl;
        logic [ID_W-1:0]   cid;
        repeat (n_items) begin
            hold_off(idle_pct);
            wall_clock_us = wall_clock_us + TIME_W'($urandom_range(0, 20000));
            if ($urandom_range(39) == 0) wall_clock_us = random_time();
            now_us = wall_clock_us;
            if ($urandom_range(49) == 0) now_us = random_time();
            ivl = IVL_W'($urandom_range(0, 40));
            if ($urandom_range(14) == 0) ivl = IVL_W'($urandom);
            cid = tbl_id[$urandom_range(SLOTS - 1)];
            pick = $urandom_range(99);
            if (pick < 15) cid = '0;
            else if (pick < 30) cid = ID_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 35) cmd = CMD_SCHEDULE;
            else if (pick < 55) cmd = CMD_CANCEL;
            else if (pick < 85) cmd = CMD_TICK;
            else cmd = CMD_QUERY;
            send_timer_cmd(cmd, now_us, ivl, 1'($urandom_range(1)), cid);
        end
    endtask

    initial begin
        start          <= 1'b0;
        i_command      <= CMD_QUERY;
        i_now_us       <= '0;
        i_interval_ms  <= '0;
        i_repeat_flag  <= 1'b0;
        i_cancel_id    <= '0;
        i_rst_n        <= 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        wall_clock_us  = 48'd5_000_000;
        prev_issued_id = '0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_id[s]    = '0;
            tbl_ivl[s]   = '0;
            tbl_rep[s]   = 1'b0;
            tbl_start[s] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_query();
        test_deadline_edges();
        test_cancel_noop();
        test_wait_saturation();
        test_table_full();
        test_random(120, 0);
        test_random(115, 54);
        test_random(115, 32);

        // Drain: every expected result, then time for a command that gives none.
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
src/ttsch_pkg.sv
src/ttsch_slot_mem.sv
src/timer_table_scheduler.sv
verif/tb.sv
